### rtl/stq_pkg.sv
// package for the sorted timer queue: sizes, codes, beat types, fsm states
// no dependencies
package stq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int LINK_W      = $clog2(TIMER_SLOTS + 1);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam logic [LINK_W-1:0] NIL_CODE = LINK_W'(TIMER_SLOTS);

    // one memory word per slot: link, stamp, period, rearm
    localparam int ENTRY_W = LINK_W + 32 + 32 + 1;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  timer_id;
        logic [31:0] interval;
        logic        repeat_req;
    } stq_in_t;

    typedef struct packed {
        logic        status;
        logic        fired;
        logic [3:0]  fired_id;
        logic [31:0] clock_now;
        logic        last;
    } stq_out_t;

    typedef struct packed {
        logic [LINK_W-1:0] link;
        logic [31:0]       stamp;
        logic [31:0]       period;
        logic              rearm;
    } stq_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_CHK,
        ST_INS_START,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_PREV_RD,
        ST_INS_PREV_WR,
        ST_STOP_RD,
        ST_STOP_CHK,
        ST_STOP_PREV_RD,
        ST_STOP_PREV_WR,
        ST_DONE
    } stq_state_t;

endpackage

### rtl/sorted_timer_queue_top.sv
// sorted timer queue top level: control sequencer around one slot memory
// depends on stq_pkg and stq_ram
//
// usage
//   command channel: start with cmd (func, timer_id, interval, repeat_req)
//   is taken at a clock edge where start is high and busy is low.
//   results appear one per cycle-long result_valid strobe; the receiver
//   cannot stall, and last marks the final beat of a command. cfg_we writes
//   tick_step (reset value 1) unchecked: use only while the block is idle.
// sequencing
//   each queue link visited costs a memory read, then a compare, as the
//   slot memory has a single port. stop and start walk at most sixteen
//   links. a tick reads and checks the head in a loop, plus one insertion
//   walk per rearmed timer.
// reset
//   clock 0, queue empty, all queued flags cleared; the slot memory is
//   not cleared, entries are written when a timer starts.
module sorted_timer_queue_top
    import stq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  stq_in_t     cmd,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        result_valid,
    output stq_out_t    result
);

    stq_state_t state_reg, state_next;

    logic [15:0]            step_reg;
    logic [31:0]            clock_reg, clock_next;
    logic [LINK_W-1:0]      head_reg, head_next;
    logic [TIMER_SLOTS-1:0] queued_reg, queued_next;

    stq_in_t                cmd_reg;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [31:0]            ins_period_reg, ins_period_next;
    logic [LINK_W-1:0]      it_reg, it_next;
    logic [LINK_W-1:0]      prev_reg, prev_next;
    logic [LINK_W-1:0]      link_reg, link_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SLOT_W:0]        walk_reg, walk_next;
    logic                   from_tick_reg, from_tick_next;
    logic                   fail_reg, fail_next;

    logic        mem_we;
    logic [SLOT_W-1:0] mem_addr;
    stq_entry_t  mem_wdata, mem_rdata;
    logic [ENTRY_W-1:0] rd_bits;

    stq_out_t    out_next;
    logic        out_valid_next;

    logic [31:0] elapsed;
    logic        ins_here;
    logic        cmd_slot_ok;
    logic        cmd_slot_queued;
    logic        walk_end;

    assign mem_rdata = stq_entry_t'(rd_bits);

    stq_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMER_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (ENTRY_W'(mem_wdata)),
        .rdata (rd_bits)
    );

    assign busy    = (state_reg != ST_IDLE);
    assign elapsed = clock_reg - mem_rdata.stamp;
    assign ins_here = (elapsed <= mem_rdata.period) &&
                      ((mem_rdata.period - elapsed) >= ins_period_reg);
    assign cmd_slot_ok     = ({1'b0, cmd.timer_id} < 5'(TIMER_SLOTS));
    assign cmd_slot_queued = queued_reg[cmd.timer_id[SLOT_W-1:0]];
    assign walk_end = (it_reg >= NIL_CODE) ||
                      (walk_reg == (SLOT_W+1)'(TIMER_SLOTS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.func)
                        FUNC_TICK:
                        begin
                            state_next = ST_HEAD_RD;
                        end
                        FUNC_START:
                        begin
                            state_next = (cmd_slot_ok && !cmd_slot_queued) ? ST_INS_START
                                                                           : ST_DONE;
                        end
                        FUNC_STOP:
                        begin
                            state_next = (cmd_slot_ok && cmd_slot_queued) ? ST_STOP_RD
                                                                          : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_HEAD_RD:
            begin
                if (head_reg == NIL_CODE || cnt_reg == CNT_W'(MAX_RESULTS))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_HEAD_CHK;
                end
            end

            ST_HEAD_CHK:
            begin
                if (elapsed < mem_rdata.period)
                begin
                    state_next = ST_DONE;
                end
                else if (mem_rdata.rearm)
                begin
                    state_next = ST_INS_START;
                end
                else
                begin
                    state_next = ST_HEAD_RD;
                end
            end

            ST_INS_START:
            begin
                state_next = ST_INS_RD;
            end

            ST_INS_RD:
            begin
                state_next = walk_end ? ST_INS_PREV_RD : ST_INS_CHK;
            end

            ST_INS_CHK:
            begin
                state_next = ins_here ? ST_INS_PREV_RD : ST_INS_RD;
            end

            ST_INS_PREV_RD:
            begin
                if (prev_reg >= NIL_CODE)
                begin
                    state_next = from_tick_reg ? ST_HEAD_RD : ST_DONE;
                end
                else
                begin
                    state_next = ST_INS_PREV_WR;
                end
            end

            ST_INS_PREV_WR:
            begin
                state_next = ST_STOP_PREV_WR;
            end

            ST_STOP_RD:
            begin
                state_next = walk_end ? ST_DONE : ST_STOP_CHK;
            end

            ST_STOP_CHK:
            begin
                if (it_reg[SLOT_W-1:0] == slot_reg)
                begin
                    state_next = (prev_reg >= NIL_CODE) ? ST_DONE : ST_STOP_PREV_RD;
                end
                else
                begin
                    state_next = ST_STOP_RD;
                end
            end

            ST_STOP_PREV_RD:
            begin
                state_next = ST_STOP_PREV_WR;
            end

            ST_STOP_PREV_WR:
            begin
                if (walk_reg[SLOT_W] && from_tick_reg)
                begin
                    state_next = ST_HEAD_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath, memory access and beat outputs
    always_comb
    begin
        clock_next      = clock_reg;
        head_next       = head_reg;
        queued_next     = queued_reg;
        slot_next       = slot_reg;
        ins_period_next = ins_period_reg;
        it_next         = it_reg;
        prev_next       = prev_reg;
        link_next       = link_reg;
        cnt_next        = cnt_reg;
        walk_next       = walk_reg;
        from_tick_next  = from_tick_reg;
        fail_next       = fail_reg;
        out_valid_next  = 1'b0;
        out_next        = '0;
        out_next.clock_now = clock_reg;
        mem_we          = 1'b0;
        mem_addr        = it_reg[SLOT_W-1:0];
        mem_wdata       = mem_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next  = '0;
                    fail_next = 1'b0;
                    case (cmd.func)
                        FUNC_TICK:
                        begin
                            clock_next = clock_reg + 32'(step_reg);
                        end
                        FUNC_START:
                        begin
                            if (cmd_slot_ok && !cmd_slot_queued)
                            begin
                                slot_next       = cmd.timer_id[SLOT_W-1:0];
                                ins_period_next = (cmd.interval == '0) ? 32'd1
                                                                       : cmd.interval;
                                from_tick_next  = 1'b0;
                            end
                        end
                        FUNC_STOP:
                        begin
                            fail_next  = 1'b1;
                            if (cmd_slot_ok && cmd_slot_queued)
                            begin
                                slot_next  = cmd.timer_id[SLOT_W-1:0];
                                it_next    = head_reg;
                                prev_next  = NIL_CODE;
                                walk_next  = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // read the head entry
            ST_HEAD_RD:
            begin
                if (!(head_reg == NIL_CODE || cnt_reg == CNT_W'(MAX_RESULTS)))
                begin
                    mem_addr   = head_reg[SLOT_W-1:0];
                end
            end

            // pop and fire if expired
            ST_HEAD_CHK:
            begin
                mem_addr = head_reg[SLOT_W-1:0];
                if (elapsed >= mem_rdata.period)
                begin
                    slot_next = head_reg[SLOT_W-1:0];
                    head_next = (mem_rdata.link > NIL_CODE) ? NIL_CODE
                                                            : mem_rdata.link;
                    queued_next[head_reg[SLOT_W-1:0]] = 1'b0;
                    cnt_next  = cnt_reg + 1'b1;
                    // fire beat, last clear; it is held pending, and the flush in
                    // the done state sets last on the final fired beat
                    out_valid_next    = 1'b1;
                    out_next.fired    = 1'b1;
                    out_next.fired_id = 4'(head_reg[SLOT_W-1:0]);
                    out_next.last     = 1'b0;
                    if (mem_rdata.rearm)
                    begin
                        ins_period_next = mem_rdata.period;
                        from_tick_next  = 1'b1;
                    end
                end
            end

            // write stamp, begin walk
            ST_INS_START:
            begin
                mem_we           = 1'b1;
                mem_addr         = slot_reg;
                mem_wdata.link   = NIL_CODE;
                mem_wdata.stamp  = clock_reg;
                mem_wdata.period = ins_period_reg;
                mem_wdata.rearm  = from_tick_reg ? 1'b1 : cmd_reg.repeat_req;
                it_next          = head_reg;
                prev_next        = NIL_CODE;
                walk_next        = '0;
            end

            ST_INS_RD:
            begin
                if (walk_end)
                begin
                    link_next  = (it_reg >= NIL_CODE) ? NIL_CODE : it_reg;
                    mem_addr   = slot_reg;
                end
                else
                begin
                    mem_addr   = it_reg[SLOT_W-1:0];
                end
            end

            ST_INS_CHK:
            begin
                if (ins_here)
                begin
                    link_next  = it_reg;
                    mem_addr   = slot_reg;
                end
                else
                begin
                    prev_next  = it_reg;
                    it_next    = mem_rdata.link;
                    walk_next  = walk_reg + 1'b1;
                end
            end

            // new entry read back, patch its link
            ST_INS_PREV_RD:
            begin
                mem_we         = 1'b1;
                mem_addr       = slot_reg;
                mem_wdata.link = link_reg;
                queued_next[slot_reg] = 1'b1;
                if (prev_reg >= NIL_CODE)
                begin
                    head_next  = LINK_W'(slot_reg);
                end
            end

            // read-modify-write of the predecessor: read issued here
            ST_INS_PREV_WR:
            begin
                mem_addr   = prev_reg[SLOT_W-1:0];
                link_next  = LINK_W'(slot_reg);
                prev_next  = prev_reg;
                walk_next  = {1'b1, {SLOT_W{1'b0}}};
            end

            // stop walk
            ST_STOP_RD:
            begin
                if (!walk_end)
                begin
                    mem_addr   = it_reg[SLOT_W-1:0];
                end
            end

            ST_STOP_CHK:
            begin
                if (it_reg[SLOT_W-1:0] == slot_reg)
                begin
                    fail_next = 1'b0;
                    queued_next[slot_reg] = 1'b0;
                    link_next = mem_rdata.link;
                    if (prev_reg >= NIL_CODE)
                    begin
                        head_next  = mem_rdata.link;
                    end
                    else
                    begin
                        mem_addr   = prev_reg[SLOT_W-1:0];
                        walk_next  = '0;
                    end
                end
                else
                begin
                    prev_next  = it_reg;
                    it_next    = mem_rdata.link;
                    walk_next  = walk_reg + 1'b1;
                end
            end

            // predecessor read issued last cycle, wait for data
            ST_STOP_PREV_RD:
            begin
                mem_addr   = prev_reg[SLOT_W-1:0];
            end

            // write predecessor link; shared by insert and stop
            ST_STOP_PREV_WR:
            begin
                mem_we         = 1'b1;
                mem_addr       = prev_reg[SLOT_W-1:0];
                mem_wdata.link = link_reg;
            end

            // closing beat
            ST_DONE:
            begin
                if (cnt_reg == '0 || cmd_reg.func != FUNC_TICK)
                begin
                    out_valid_next  = 1'b1;
                    out_next.status = fail_reg && (cmd_reg.func == FUNC_STOP);
                    out_next.last   = 1'b1;
                end
            end

            default:
            begin
            end
        endcase
    end

    // each fired beat is held until the next one, so the last can get its last flag
    stq_out_t pend_reg;
    logic     pend_valid_reg;
    logic     flush;

    assign flush = (state_reg == ST_DONE) && (cnt_reg != '0) &&
                   (cmd_reg.func == FUNC_TICK);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= 16'd1;
            clock_reg      <= '0;
            head_reg       <= NIL_CODE;
            queued_reg     <= '0;
            result_valid   <= 1'b0;
            pend_valid_reg <= 1'b0;
            from_tick_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            head_reg      <= head_next;
            queued_reg    <= queued_next;
            from_tick_reg <= from_tick_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            result_valid <= 1'b0;
            if (out_valid_next && out_next.fired)
            begin
                result_valid   <= pend_valid_reg;
                pend_valid_reg <= 1'b1;
            end
            else if (flush)
            begin
                result_valid   <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (out_valid_next)
            begin
                result_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        ins_period_reg <= ins_period_next;
        it_reg         <= it_next;
        prev_reg       <= prev_next;
        link_reg       <= link_next;
        walk_reg       <= walk_next;
        fail_reg       <= fail_next;
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        if (out_valid_next && out_next.fired)
        begin
            result   <= pend_reg;
            pend_reg <= out_next;
        end
        else if (flush)
        begin
            result      <= pend_reg;
            result.last <= 1'b1;
        end
        else if (out_valid_next)
        begin
            result <= out_next;
        end
    end

endmodule

### rtl/stq_ram.sv
// generic single-port synchronous ram, registered read
// no dependencies
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/stq_checker.sv
// port-level checker for the sorted timer queue, bound to the top level
// depends on stq_pkg
module stq_checker
    import stq_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     result_valid,
    input stq_out_t result
);

    // a beat never comes while idle and unstarted
    a_no_idle_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(busy) && !busy |-> !result_valid)
        else $error("result beat while idle");

    // accepted command makes the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("not busy after accept");

    // a non-fired beat is always the last one
    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.fired |-> result.last)
        else $error("plain beat without last");

    // status only on non-fired beats
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.fired |-> !result.status)
        else $error("status set on fired beat");

endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

### test/testbench.sv
// self-checking testbench for sorted_timer_queue_top: driver, monitor and timer queue predictor
// depends on stq_pkg and the sorted_timer_queue_top rtl
module testbench;
    import stq_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    stq_in_t     cmd;
    logic        busy;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        result_valid;
    stq_out_t    result;

    sorted_timer_queue_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .result(result)
    );

    // predictor state
    logic [15:0] step_q;
    logic [31:0] clk_q;
    logic [4:0]  head_q;
    logic        queued_q [TIMER_SLOTS];
    logic [4:0]  link_q   [TIMER_SLOTS];
    logic [31:0] stamp_q  [TIMER_SLOTS];
    logic [31:0] period_q [TIMER_SLOTS];
    logic        rearm_q  [TIMER_SLOTS];

    stq_in_t  cmd_queue [$];
    int       gap_queue [$];
    stq_out_t expected_beats [$];
    int       error_count;
    int       accepted_count;
    int       stall_cycles;
    int       gap_left;
    logic     driving;
    logic     busy_at_edge;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    // sorted insertion of one slot by remaining time
    function automatic void timer_insert(input logic [3:0] slot);
        logic [4:0]  prev;
        logic [4:0]  it;
        logic [31:0] el;
        int          n;
        prev = NIL_CODE;
        it = head_q;
        n = 0;
        while (it < NIL_CODE && n < TIMER_SLOTS)
        begin
            el = clk_q - stamp_q[it[3:0]];
            if (el <= period_q[it[3:0]] && period_q[it[3:0]] - el >= period_q[slot])
                break;
            prev = it;
            it = link_q[it[3:0]];
            n++;
        end
        if (it >= NIL_CODE)
            it = NIL_CODE;
        link_q[slot] = it;
        if (prev >= NIL_CODE)
            head_q = {1'b0, slot};
        else
            link_q[prev[3:0]] = {1'b0, slot};
        queued_q[slot] = 1'b1;
    endfunction

    function automatic logic timer_unlink(input logic [3:0] slot);
        logic [4:0] prev;
        logic [4:0] it;
        int         n;
        prev = NIL_CODE;
        it = head_q;
        n = 0;
        if (!queued_q[slot])
            return 1'b0;
        while (it < NIL_CODE && it != {1'b0, slot} && n < TIMER_SLOTS)
        begin
            prev = it;
            it = link_q[it[3:0]];
            n++;
        end
        if (it != {1'b0, slot})
            return 1'b0;
        if (prev >= NIL_CODE)
            head_q = link_q[slot];
        else
            link_q[prev[3:0]] = link_q[slot];
        queued_q[slot] = 1'b0;
        return 1'b1;
    endfunction

    function automatic stq_out_t make_beat(input logic st, input logic fi,
                                           input logic [3:0] id);
        stq_out_t b;
        b.status = st;
        b.fired = fi;
        b.fired_id = id;
        b.clock_now = clk_q;
        b.last = 1'b0;
        return b;
    endfunction

    // expected beats of one accepted command
    function automatic void predict_timer_beats(input stq_in_t c);
        stq_out_t   beats [$];
        stq_out_t   b;
        logic [3:0] h;
        logic       ok;
        case (c.func)
            FUNC_TICK:
            begin
                clk_q = clk_q + 32'(step_q);
                while (beats.size() < MAX_RESULTS && head_q < NIL_CODE)
                begin
                    h = head_q[3:0];
                    if (clk_q - stamp_q[h] < period_q[h])
                        break;
                    head_q = link_q[h];
                    if (head_q > NIL_CODE)
                        head_q = NIL_CODE;
                    queued_q[h] = 1'b0;
                    if (rearm_q[h])
                    begin
                        stamp_q[h] = clk_q;
                        timer_insert(h);
                    end
                    beats.push_back(make_beat(1'b0, 1'b1, h));
                end
                if (beats.size() == 0)
                    beats.push_back(make_beat(1'b0, 1'b0, 4'd0));
            end
            FUNC_START:
            begin
                if (!queued_q[c.timer_id])
                begin
                    stamp_q[c.timer_id] = clk_q;
                    period_q[c.timer_id] = (c.interval == 32'd0) ? 32'd1 : c.interval;
                    rearm_q[c.timer_id] = c.repeat_req;
                    timer_insert(c.timer_id);
                end
                beats.push_back(make_beat(1'b0, 1'b0, 4'd0));
            end
            FUNC_STOP:
            begin
                ok = timer_unlink(c.timer_id);
                beats.push_back(make_beat(!ok, 1'b0, 4'd0));
            end
            default:
                beats.push_back(make_beat(1'b0, 1'b0, 4'd0));
        endcase
        b = beats[$];
        b.last = 1'b1;
        beats[$] = b;
        foreach (beats[i])
            expected_beats.push_back(beats[i]);
    endfunction

    // driver: one command beat per handshake, random gap before each
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else if (start && !busy_at_edge)
        begin
            // previous beat taken at the last rising edge
            if (driving && cmd_queue.size() > 0 && gap_queue[0] == 0)
            begin
                cmd <= cmd_queue[0];
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
                if (gap_queue.size() > 0)
                    gap_left <= gap_queue[0] - 1;
            end
        end
        else if (!start && driving && cmd_queue.size() > 0)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else
            begin
                cmd <= cmd_queue[0];
                start <= 1'b1;
            end
        end
    end

    // edge bookkeeping: acceptance and predictor update
    always @(posedge clk)
    begin
        busy_at_edge <= busy;
        if (rst_n && start && !busy)
        begin
            predict_timer_beats(cmd_queue.pop_front());
            void'(gap_queue.pop_front());
            accepted_count++;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                stall_cycles <= 0;
                if (expected_beats.size() == 0)
                    report($sformatf("unexpected beat %p", result));
                else
                begin
                    stq_out_t e;
                    e = expected_beats.pop_front();
                    if (result.status !== e.status)
                        report($sformatf("status %b want %b", result.status, e.status));
                    if (result.fired !== e.fired)
                        report($sformatf("fired %b want %b", result.fired, e.fired));
                    if (result.fired_id !== e.fired_id)
                        report($sformatf("fired_id %0d want %0d", result.fired_id,
                                         e.fired_id));
                    if (result.clock_now !== e.clock_now)
                        report($sformatf("clock_now %h want %h", result.clock_now,
                                         e.clock_now));
                    if (result.last !== e.last)
                        report($sformatf("last %b want %b", result.last, e.last));
                end
            end
            else if (start && !busy)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL sorted_timer_queue_top");
            $finish;
        end
    end

    task automatic add_cmd(input logic [1:0] f, input logic [3:0] id,
                           input logic [31:0] ivl, input logic rep);
        stq_in_t c;
        c.func = f;
        c.timer_id = id;
        c.interval = ivl;
        c.repeat_req = rep;
        cmd_queue.push_back(c);
        gap_queue.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
    endtask

    // let all queued commands drain, then settle
    task automatic run_phase();
        driving = 1'b1;
        wait (cmd_queue.size() == 0);
        wait (expected_beats.size() == 0);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_step(input logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        step_q = v;
    endtask

    // random mix, mostly starts and ticks with small intervals
    task automatic random_phase(input int count, input int ivl_max);
        logic [31:0] ivl;
        int          sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0: ivl = $urandom;
                1: ivl = 32'd0;
                default: ivl = $urandom_range(0, ivl_max);
            endcase
            if (sel < 40)
                add_cmd(FUNC_TICK, 4'($urandom), $urandom, 1'($urandom));
            else if (sel < 75)
                add_cmd(FUNC_START, 4'($urandom), ivl, 1'($urandom));
            else if (sel < 95)
                add_cmd(FUNC_STOP, 4'($urandom), $urandom, 1'($urandom));
            else
                add_cmd(FUNC_NOP, 4'($urandom), $urandom, 1'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        driving = 1'b0;
        error_count = 0;
        accepted_count = 0;
        stall_cycles = 0;
        busy_at_edge = 1'b0;
        step_q = 16'd1;
        clk_q = '0;
        head_q = NIL_CODE;
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            queued_q[i] = 1'b0;
            link_q[i] = NIL_CODE;
            stamp_q[i] = '0;
            period_q[i] = '0;
            rearm_q[i] = 1'b0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, all codes, repeat start, failed stop, many firing at once
        add_cmd(FUNC_TICK, 4'd0, 32'd0, 1'b0);
        add_cmd(FUNC_STOP, 4'd15, 32'hFFFF_FFFF, 1'b1);
        add_cmd(FUNC_START, 4'd0, 32'd0, 1'b1);
        add_cmd(FUNC_START, 4'd15, 32'hFFFF_FFFF, 1'b0);
        add_cmd(FUNC_START, 4'd15, 32'd5, 1'b1);
        add_cmd(FUNC_NOP, 4'd7, 32'h5555_AAAA, 1'b1);
        for (int i = 1; i < 15; i++)
            add_cmd(FUNC_START, 4'(i), 32'd2, 1'b1);
        add_cmd(FUNC_TICK, 4'd0, 32'd0, 1'b0);
        add_cmd(FUNC_TICK, 4'd0, 32'd0, 1'b0);
        add_cmd(FUNC_STOP, 4'd15, 32'd0, 1'b0);
        add_cmd(FUNC_STOP, 4'd3, 32'd0, 1'b0);
        add_cmd(FUNC_TICK, 4'd0, 32'd0, 1'b0);
        run_phase();

        // random phases across tick_step settings
        write_step(16'd1);
        random_phase(120, 8);
        run_phase();
        write_step(16'hFFFF);
        random_phase(120, 300000);
        run_phase();
        write_step(16'd0);
        random_phase(60, 8);
        run_phase();
        write_step(16'($urandom_range(2, 100)));
        random_phase(150, 400);
        run_phase();

        if (error_count == 0)
            $display("PASS sorted_timer_queue_top");
        else
            $display("FAIL sorted_timer_queue_top");
        $finish;
    end
endmodule

### files.f
rtl/stq_pkg.sv
rtl/stq_ram.sv
rtl/sorted_timer_queue_top.sv
rtl/stq_checker.sv
test/testbench.sv
